[rtl/pqad_pkg.sv]
`timescale 1ns / 1ps
package pqad_pkg;
    localparam int MAX_SUBQ      = 8;
    localparam int MAX_CENTROIDS = 256;
    localparam int MAX_SUBDIM    = 32;
    localparam int SQ_W   = $clog2(MAX_SUBQ);
    localparam int CENT_W = $clog2(MAX_CENTROIDS);
    localparam int DIM_W  = $clog2(MAX_SUBDIM);
    localparam int CB_AW  = SQ_W + CENT_W + DIM_W;
    localparam int TB_AW  = SQ_W + CENT_W;
    // A coordinate spans minus one to plus one inclusive, which needs 16 bits.
    localparam int COORD_W = 16;
    localparam int ENTRY_W = 40;
    localparam int DIST_W  = 44;
    localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
    localparam logic signed [DIST_W-1:0] ONE_Q28 = DIST_W'(64'sd1 <<< 28);

    typedef enum logic [1:0] {
        ACT_CODEBOOK = 2'd0,
        ACT_QUERY    = 2'd1,
        ACT_CODE     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_NSQ   = 2'd0,
        REG_BITS  = 2'd1,
        REG_NCENT = 2'd2,
        REG_SDIM  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_CODE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [SQ_W:0]   nsq;
        logic [3:0]      bits;
        logic [CENT_W:0] ncent;
        logic [DIM_W:0]  sdim;
    } cfg_t;
endpackage

[rtl/pqad_regs.sv]
`timescale 1ns / 1ps
module pqad_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pqad_pkg::cfg_t    cfg
);
    import pqad_pkg::*;

    logic [3:0] nsq_reg, bits_reg, nsq_next, bits_next;
    logic [8:0] ncent_reg, ncent_next;
    logic [5:0] sdim_reg, sdim_next;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        nsq_next   = nsq_reg;
        bits_next  = bits_reg;
        ncent_next = ncent_reg;
        sdim_next  = sdim_reg;
        if (wr_en)
        begin
            case (idx)
                REG_NSQ:   nsq_next   = pwdata[3:0];
                REG_BITS:  bits_next  = pwdata[3:0];
                REG_NCENT: ncent_next = pwdata[8:0];
                REG_SDIM:  sdim_next  = pwdata[5:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsq_reg   <= 4'd8;
            bits_reg  <= 4'd8;
            ncent_reg <= 9'd256;
            sdim_reg  <= 6'd8;
        end
        else
        begin
            nsq_reg   <= nsq_next;
            bits_reg  <= bits_next;
            ncent_reg <= ncent_next;
            sdim_reg  <= sdim_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_NSQ:   prdata = {28'd0, nsq_reg};
            REG_BITS:  prdata = {28'd0, bits_reg};
            REG_NCENT: prdata = {23'd0, ncent_reg};
            REG_SDIM:  prdata = {26'd0, sdim_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // Registers are used clamped to their legal ranges.
    always_comb
    begin
        if (nsq_reg == 4'd0)
            cfg.nsq = (SQ_W+1)'(1);
        else if (nsq_reg > 4'(MAX_SUBQ))
            cfg.nsq = (SQ_W+1)'(MAX_SUBQ);
        else
            cfg.nsq = (SQ_W+1)'(nsq_reg);
        if (bits_reg == 4'd0)
            cfg.bits = 4'd1;
        else if (bits_reg > 4'd8)
            cfg.bits = 4'd8;
        else
            cfg.bits = bits_reg;
        if (ncent_reg == 9'd0)
            cfg.ncent = (CENT_W+1)'(1);
        else if (ncent_reg > 9'(MAX_CENTROIDS))
            cfg.ncent = (CENT_W+1)'(MAX_CENTROIDS);
        else
            cfg.ncent = (CENT_W+1)'(ncent_reg);
        if (sdim_reg == 6'd0)
            cfg.sdim = (DIM_W+1)'(1);
        else if (sdim_reg > 6'(MAX_SUBDIM))
            cfg.sdim = (DIM_W+1)'(MAX_SUBDIM);
        else
            cfg.sdim = (DIM_W+1)'(sdim_reg);
    end
endmodule

[rtl/pq_asymmetric_distance.sv]
`timescale 1ns / 1ps
// Product-quantizer asymmetric distance engine. A codebook store (one
// 16-bit coordinate per subquantizer, centroid and coordinate) and a lookup
// table (one signed 40-bit Q.28 entry per subquantizer and centroid) live in
// two synchronous memories with registered read data. A request with action
// 0 writes one codebook coordinate. A request with action 1 walks every
// centroid in use of its subquantizer: one codebook and one table read are
// issued per cycle and the entry minus query times coordinate is written
// back once the read data and then the product are registered; coordinate 0
// starts the row from zero. A request with action 2 reads one table entry
// per subquantizer in use, one per cycle, and adds them onto 1.0; it may
// then wait for the output register to empty. A code at or above
// num_centroids stops the scan early and yields status 1 and distance 0.
// Only code requests produce a result; the result sits in an output register
// while the next request is taken. Neither memory is cleared at reset:
// entries must be written before they are read. Coordinates are Q2.14 and
// saturated to minus one to one, table entries saturate to 40 bits.
module pq_asymmetric_distance (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: action[1:0], sub_index[4:2], centroid_index[12:5],
    // coord_index[17:13], value[33:18], code_word[97:34], zero fill to 104.
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: distance[43:0]; zero fill to 48.
    output logic [47:0]  m_tdata,
    // m_tuser: status.
    output logic         m_tuser
);
    import pqad_pkg::*;

    cfg_t cfg;

    pqad_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request fields.
    action_t             in_act;
    logic [SQ_W-1:0]     in_sq;
    logic [CENT_W-1:0]   in_k;
    logic [DIM_W-1:0]    in_c;
    logic signed [15:0]  in_val;
    logic signed [COORD_W-1:0] in_coord;
    logic [63:0]         in_word;

    assign in_act  = action_t'(s_tdata[1:0]);
    assign in_sq   = s_tdata[4:2];
    assign in_k    = s_tdata[12:5];
    assign in_c    = s_tdata[17:13];
    assign in_val  = s_tdata[33:18];
    assign in_word = s_tdata[97:34];

    always_comb
    begin
        if (in_val > 16'sd16384)
            in_coord = COORD_W'(16'sd16384);
        else if (in_val < -16'sd16384)
            in_coord = COORD_W'(-16'sd16384);
        else
            in_coord = in_val[COORD_W-1:0];
    end

    // Memories.
    logic [COORD_W-1:0] cb_mem [0:(1<<CB_AW)-1];
    logic [ENTRY_W-1:0] tb_mem [0:(1<<TB_AW)-1];
    logic               cb_we, tb_we;
    logic [CB_AW-1:0]   cb_waddr, cb_raddr;
    logic [TB_AW-1:0]   tb_waddr, tb_raddr;
    logic [COORD_W-1:0] cb_wdata, cb_rdata_reg;
    logic [ENTRY_W-1:0] tb_wdata, tb_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cb_we)
            cb_mem[cb_waddr] <= cb_wdata;
        cb_rdata_reg <= cb_mem[cb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
            tb_mem[tb_waddr] <= tb_wdata;
        tb_rdata_reg <= tb_mem[tb_raddr];
    end

    // Control.
    state_t state_reg, state_next;
    logic [CENT_W:0]       cnt_reg, cnt_next;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIM_W-1:0]      c_reg;
    logic signed [COORD_W-1:0] q_reg;
    logic [63:0]           word_reg;
    logic                  code_reg;
    logic                  accept;
    logic                  q_ok;

    // Pipeline of the query walk: stage 1 carries memory read data.
    logic                  p1_vld_reg, p2_vld_reg;
    logic [CENT_W-1:0]     p1_k_reg, p2_k_reg;
    logic signed [2*COORD_W-1:0] prod_reg;
    logic signed [ENTRY_W-1:0]   base_reg;

    // Code accumulation.
    logic                  r_vld_reg;
    logic                  bad_reg;
    logic signed [DIST_W-1:0] acc_reg;
    logic [CENT_W:0]       code;
    logic [6:0]            off;
    logic [63:0]           shifted;

    logic                  out_full_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic                  out_stat_reg;

    assign accept = s_tvalid && s_tready;
    assign q_ok   = ({1'b0, in_sq} < cfg.nsq) && ({1'b0, in_c} < cfg.sdim);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        off     = 7'(cnt_reg[SQ_W-1:0]) * 7'(cfg.bits);
        shifted = word_reg >> off[5:0];
        if (off[6])
            code = '0;
        else
            code = (CENT_W+1)'(shifted[CENT_W-1:0] & ((8'd1 << cfg.bits) - 8'd1));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_act == ACT_QUERY && q_ok)
                    state_next = ST_QUERY;
                else if (accept && in_act == ACT_CODE)
                    state_next = ST_CODE;
            end
            ST_QUERY:
                if (cnt_reg == cfg.ncent - 1'b1)
                    state_next = ST_DRAIN;
            ST_CODE:
                if (code >= cfg.ncent || cnt_reg == (CENT_W+1)'(cfg.nsq) - 1'b1)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                // Only a code request leaves a result behind.
                if (!p1_vld_reg && !p2_vld_reg && !r_vld_reg)
                    state_next = code_reg ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (!out_full_reg || m_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:  cnt_next = '0;
            ST_QUERY: cnt_next = cnt_reg + 1'b1;
            ST_CODE:  cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Memory port drive.
    always_comb
    begin
        cb_we    = 1'b0;
        cb_waddr = {in_sq, in_k, in_c};
        cb_wdata = in_coord;
        if (accept && in_act == ACT_CODEBOOK && q_ok
            && ({1'b0, in_k} < cfg.ncent))
            cb_we = 1'b1;
        cb_raddr = {sq_reg, cnt_reg[CENT_W-1:0], c_reg};
        if (state_reg == ST_CODE)
            tb_raddr = {cnt_reg[SQ_W-1:0], code[CENT_W-1:0]};
        else
            tb_raddr = {sq_reg, cnt_reg[CENT_W-1:0]};
    end

    logic signed [ENTRY_W+1:0] diff;
    always_comb
    begin
        diff     = (ENTRY_W+2)'(base_reg) - (ENTRY_W+2)'(prod_reg);
        tb_we    = p2_vld_reg;
        tb_waddr = {sq_reg, p2_k_reg};
        if (diff > (ENTRY_W+2)'(ENTRY_MAX))
            tb_wdata = ENTRY_MAX;
        else if (diff < (ENTRY_W+2)'(ENTRY_MIN))
            tb_wdata = ENTRY_MIN;
        else
            tb_wdata = diff[ENTRY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            r_vld_reg    <= 1'b0;
            out_full_reg <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            p1_vld_reg <= (state_reg == ST_QUERY);
            p2_vld_reg <= p1_vld_reg;
            r_vld_reg  <= (state_reg == ST_CODE) && (code < cfg.ncent);
            if (accept)
                bad_reg <= 1'b0;
            else if (state_reg == ST_CODE && code >= cfg.ncent)
                bad_reg <= 1'b1;
            if (state_reg == ST_OUT && (!out_full_reg || m_tready))
                out_full_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg   <= in_sq;
            c_reg    <= in_c;
            q_reg    <= in_coord;
            word_reg <= in_word;
            code_reg <= (in_act == ACT_CODE);
            acc_reg  <= ONE_Q28;
        end
        p1_k_reg <= cnt_reg[CENT_W-1:0];
        p2_k_reg <= p1_k_reg;
        // Stage 2: multiply and choose the starting entry.
        prod_reg <= q_reg * $signed(cb_rdata_reg);
        base_reg <= (c_reg == '0) ? '0 : $signed(tb_rdata_reg);
        if (r_vld_reg)
            acc_reg <= acc_reg + DIST_W'($signed(tb_rdata_reg));
        if (state_reg == ST_OUT && (!out_full_reg || m_tready))
        begin
            out_dist_reg <= bad_reg ? '0 : acc_reg;
            out_stat_reg <= bad_reg;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {4'd0, out_dist_reg};
    assign m_tuser  = out_stat_reg;
endmodule
